// File: rtl/gcv_pkg.sv
// gcv_pkg: shared types and codes for the flash gc victim selector and clean pool
// used by gcv_rem and flash_gc_victim_and_free_pool_top
// no dependencies
`timescale 1ns / 1ps

package gcv_pkg;

  localparam int RND_W     = 16;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_RECLAIM = 2'd1,
    MODE_TAKE    = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_POOL_FULL  = 2'd2,
    ST_POOL_EMPTY = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_EXCLUDE  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TAKE,
    S_SCAN1,
    S_EVAL,
    S_DIV,
    S_SCAN2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

// File: rtl/gcv_ram.sv
// gcv_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module gcv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gcv_rem.sv
// gcv_rem: bit-serial restoring remainder, one dividend bit per cycle
// depends on gcv_pkg
`timescale 1ns / 1ps

module gcv_rem #(
  parameter int DivW = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gcv_pkg::RND_W-1:0]   dividend_i,
  input  logic [DivW-1:0]             divisor_i,
  output logic [DivW-1:0]             rem_o,
  output gcv_pkg::rem_stat_t          stat_o
);

  localparam int CntW = $clog2(gcv_pkg::RND_W);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [gcv_pkg::RND_W-1:0] dvd_q, dvd_d;
  logic [DivW-1:0]           r_q, r_d;
  logic [DivW:0]             trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    r_d    = r_q;
    trial  = {r_q, dvd_q[gcv_pkg::RND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(gcv_pkg::RND_W - 1);
      dvd_d  = dividend_i;
      r_d    = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits back in DivW bits
      if (trial >= {1'b0, divisor_i}) begin
        r_d = DivW'(trial - {1'b0, divisor_i});
      end else begin
        r_d = trial[DivW-1:0];
      end
      dvd_d = {dvd_q[gcv_pkg::RND_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    r_q   <= r_d;
  end

  assign rem_o       = r_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: rtl/flash_gc_victim_and_free_pool_top.sv
// flash_gc_victim_and_free_pool_top: greedy gc victim selection over a block record
// memory plus a fifo of clean blocks; depends on gcv_pkg, gcv_ram, gcv_rem
//
//   channel | dir | handshake                  | beat contents
//   in      | in  | in_valid_i / in_stall_o    | mode, block_index, valid_pages,
//           |     |                            | holds_data, region_one, random_value
//   out     | out | out_valid_o / out_stall_i  | chosen_block, status
//   cfg     | in  | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// write, reserved, pool-full reclaim and empty take go to S_DONE, other takes via S_TAKE
// reclaim: up to two passes over the record memory through its single read port,
// plus a 16 step serial remainder for the tie pick
// after reset a clearing pass fills the record memory and the pool; in_stall_o stays
// high meanwhile (cfg writes still taken)
// a finished result waits in the output register while out_stall_i is high
`timescale 1ns / 1ps

module flash_gc_victim_and_free_pool_top #(
  parameter int NUM_BLOCKS          = 1024,
  parameter int POOL_DEPTH          = 16,
  parameter int MAX_PAGES_PER_BLOCK = 256,
  localparam int BW                 = $clog2(NUM_BLOCKS),
  localparam int CW                 = $clog2(MAX_PAGES_PER_BLOCK + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gcv_pkg::MODE_W-1:0]      mode_i,
  input  logic [BW-1:0]                   block_index_i,
  input  logic [CW-1:0]                   valid_pages_i,
  input  logic                            holds_data_i,
  input  logic                            region_one_i,
  input  logic [gcv_pkg::RND_W-1:0]       random_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [BW-1:0]                   chosen_block_o,
  output logic [gcv_pkg::STATUS_W-1:0]    status_o,
  input  logic                            cfg_we_i,
  input  logic [gcv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CW-1:0]                   cfg_data_i
);

  localparam int TW      = $clog2(NUM_BLOCKS + 1);
  localparam int PW      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int FW      = $clog2(POOL_DEPTH + 1);
  localparam int RecW    = CW + 2;
  localparam int ClrLen  = (NUM_BLOCKS > POOL_DEPTH) ? NUM_BLOCKS : POOL_DEPTH;
  localparam int ClrW    = $clog2(ClrLen + 1);
  localparam int PoolLo  = NUM_BLOCKS - ((POOL_DEPTH < NUM_BLOCKS) ? POOL_DEPTH : NUM_BLOCKS);
  localparam int PpbRst  = (MAX_PAGES_PER_BLOCK < 64) ? MAX_PAGES_PER_BLOCK : 64;

  gcv_pkg::state_e  state_q, state_d;

  // configuration
  logic [CW-1:0]    ppb_q;
  logic             excl_q;

  // clearing pass
  logic [ClrW-1:0]  clr_q, clr_d;
  logic [BW-1:0]    pv_q, pv_d;

  // pool pointers
  logic [PW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [FW-1:0]    fill_q, fill_d;

  // scan
  logic [BW-1:0]    iss_q, iss_d;
  logic             iss_end_q, iss_end_d;
  logic             rd_v_q, rd_v_d;
  logic [BW-1:0]    rd_idx_q, rd_idx_d;

  // search payload
  logic [CW-1:0]    min_q, min_d;
  logic [TW-1:0]    ties_q, ties_d;
  logic [TW-1:0]    pick_q, pick_d;
  logic [TW-1:0]    seen_q, seen_d;
  logic [gcv_pkg::RND_W-1:0] rnd_q, rnd_d;

  // result and output register
  logic [BW-1:0]    res_blk_q, res_blk_d;
  gcv_pkg::status_e res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  logic [BW-1:0]    out_blk_q, out_blk_d;
  gcv_pkg::status_e out_st_q, out_st_d;

  // memories
  logic             rec_we;
  logic [BW-1:0]    rec_waddr;
  logic [RecW-1:0]  rec_wdata, rec_rdata;
  logic             pool_we;
  logic [PW-1:0]    pool_waddr;
  logic [BW-1:0]    pool_wdata, pool_rdata;

  // remainder unit
  logic             rem_start;
  logic [TW-1:0]    rem_val;
  gcv_pkg::rem_stat_t rem_stat;

  logic             in_acc;
  logic [CW-1:0]    rd_cnt;
  logic             rd_use, rd_reg, cand, last, hit;

  gcv_ram #(.Width(RecW), .Depth(NUM_BLOCKS)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (iss_q),
    .rdata_o (rec_rdata)
  );

  gcv_ram #(.Width(BW), .Depth(POOL_DEPTH)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (head_q),
    .rdata_o (pool_rdata)
  );

  gcv_rem #(.DivW(TW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rnd_q),
    .divisor_i  (ties_q),
    .rem_o      (rem_val),
    .stat_o     (rem_stat)
  );

  assign in_stall_o = (state_q != gcv_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // record fields of the beat coming back from the memory
  assign rd_cnt = rec_rdata[CW-1:0];
  assign rd_use = rec_rdata[CW];
  assign rd_reg = rec_rdata[CW+1];
  assign cand   = rd_use && !(excl_q && rd_reg && (rd_cnt != '0));
  assign last   = rd_v_q && (rd_idx_q == BW'(NUM_BLOCKS - 1));
  assign hit    = (state_q == gcv_pkg::S_SCAN2) && rd_v_q && cand &&
                  (rd_cnt == min_q) && (seen_q == pick_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pv_d        = pv_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    iss_d       = '0;
    iss_end_d   = 1'b0;
    rd_v_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    min_d       = min_q;
    ties_d      = ties_q;
    pick_d      = pick_q;
    seen_d      = seen_q;
    rnd_d       = rnd_q;
    res_blk_d   = res_blk_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_blk_d   = out_blk_q;
    out_st_d    = out_st_q;
    rec_we      = 1'b0;
    rec_waddr   = rd_idx_q;
    rec_wdata   = '0;
    pool_we     = 1'b0;
    pool_waddr  = tail_q;
    pool_wdata  = rd_idx_q;
    rem_start   = 1'b0;

    // shared sequential read of the record memory, one address per cycle
    if (state_q == gcv_pkg::S_SCAN1 || state_q == gcv_pkg::S_SCAN2) begin
      iss_d     = iss_q;
      iss_end_d = iss_end_q;
      if (!iss_end_q) begin
        rd_v_d   = 1'b1;
        rd_idx_d = iss_q;
        if (iss_q == BW'(NUM_BLOCKS - 1)) begin
          iss_end_d = 1'b1;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
    end

    case (state_q)
      gcv_pkg::S_CLEAR: begin
        if (clr_q < ClrW'(NUM_BLOCKS)) begin
          rec_we    = 1'b1;
          rec_waddr = clr_q[BW-1:0];
          rec_wdata = {1'b0, (clr_q < ClrW'(PoolLo)), {CW{1'b0}}};
        end
        if (clr_q < ClrW'(POOL_DEPTH)) begin
          pool_we    = 1'b1;
          pool_waddr = clr_q[PW-1:0];
          pool_wdata = pv_q;
          pv_d = (pv_q == '0) ? BW'(NUM_BLOCKS - 1) : pv_q - 1'b1;
        end
        if (clr_q == ClrW'(ClrLen - 1)) begin
          state_d = gcv_pkg::S_IDLE;
        end
        clr_d = clr_q + 1'b1;
      end
      gcv_pkg::S_IDLE: begin
        if (in_acc) begin
          res_blk_d = '0;
          res_st_d  = gcv_pkg::ST_OK;
          rnd_d     = random_value_i;
          state_d   = gcv_pkg::S_DONE;
          case (mode_i)
            gcv_pkg::MODE_WRITE: begin
              if ({1'b0, block_index_i} < (BW+1)'(NUM_BLOCKS)) begin
                rec_we    = 1'b1;
                rec_waddr = block_index_i;
                rec_wdata = {region_one_i, holds_data_i, valid_pages_i};
              end
            end
            gcv_pkg::MODE_RECLAIM: begin
              if (fill_q >= FW'(POOL_DEPTH)) begin
                res_st_d = gcv_pkg::ST_POOL_FULL;
              end else begin
                min_d   = ppb_q;
                ties_d  = '0;
                state_d = gcv_pkg::S_SCAN1;
              end
            end
            gcv_pkg::MODE_TAKE: begin
              if (fill_q == '0) begin
                res_st_d = gcv_pkg::ST_POOL_EMPTY;
              end else begin
                state_d = gcv_pkg::S_TAKE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      gcv_pkg::S_TAKE: begin
        // pool read at the head was issued on the accepting edge
        res_blk_d = pool_rdata;
        head_d    = (head_q == PW'(POOL_DEPTH - 1)) ? '0 : head_q + 1'b1;
        fill_d    = fill_q - 1'b1;
        state_d   = gcv_pkg::S_DONE;
      end
      gcv_pkg::S_SCAN1: begin
        if (rd_v_q && cand) begin
          if (rd_cnt < min_q) begin
            min_d  = rd_cnt;
            ties_d = TW'(1);
          end else if (rd_cnt == min_q) begin
            ties_d = ties_q + 1'b1;
          end
        end
        if (last) begin
          state_d = gcv_pkg::S_EVAL;
        end
      end
      gcv_pkg::S_EVAL: begin
        if (min_q >= ppb_q || ties_q == '0) begin
          res_st_d = gcv_pkg::ST_NO_SPACE;
          state_d  = gcv_pkg::S_DONE;
        end else begin
          rem_start = 1'b1;
          state_d   = gcv_pkg::S_DIV;
        end
      end
      gcv_pkg::S_DIV: begin
        if (rem_stat.done) begin
          pick_d  = rem_val;
          seen_d  = '0;
          state_d = gcv_pkg::S_SCAN2;
        end
      end
      gcv_pkg::S_SCAN2: begin
        if (hit) begin
          // victim: clear count and in-use, keep region, queue at the tail
          rec_we     = 1'b1;
          rec_waddr  = rd_idx_q;
          rec_wdata  = {rd_reg, 1'b0, {CW{1'b0}}};
          pool_we    = 1'b1;
          pool_waddr = tail_q;
          pool_wdata = rd_idx_q;
          tail_d     = (tail_q == PW'(POOL_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          fill_d     = fill_q + 1'b1;
          res_blk_d  = rd_idx_q;
          state_d    = gcv_pkg::S_DONE;
        end else begin
          if (rd_v_q && cand && rd_cnt == min_q) begin
            seen_d = seen_q + 1'b1;
          end
          if (last) begin
            res_st_d = gcv_pkg::ST_NO_SPACE;
            state_d  = gcv_pkg::S_DONE;
          end
        end
      end
      gcv_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_blk_d   = (res_st_q == gcv_pkg::ST_OK) ? res_blk_q : '0;
          state_d     = gcv_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gcv_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcv_pkg::S_CLEAR;
      clr_q       <= '0;
      pv_q        <= BW'(NUM_BLOCKS - 1);
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= FW'(POOL_DEPTH);
      iss_q       <= '0;
      iss_end_q   <= 1'b0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ppb_q       <= CW'(PpbRst);
      excl_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pv_q        <= pv_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      iss_q       <= iss_d;
      iss_end_q   <= iss_end_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gcv_pkg::CFG_PAGES_PER_BLOCK: ppb_q <= cfg_data_i;
          gcv_pkg::CFG_REGION_EXCLUDE:  excl_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    min_q     <= min_d;
    ties_q    <= ties_d;
    pick_q    <= pick_d;
    seen_q    <= seen_d;
    rnd_q     <= rnd_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
    out_blk_q <= out_blk_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_block_o = out_blk_q;
  assign status_o       = out_st_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(POOL_DEPTH))
    else $error("pool fill above pool size");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (fill_q < FW'(POOL_DEPTH)))
    else $error("victim queued into a full pool");

  a_hit_below_ppb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (min_q < ppb_q) && (pick_q < ties_q))
    else $error("victim picked without a valid minimum or tie index");

  a_rem_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_start |-> !rem_stat.busy && (ties_q != '0))
    else $error("remainder started while busy or with zero divisor");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gcv_pkg::S_DIV && rem_stat.done) |-> (rem_val < ties_q))
    else $error("tie pick out of range");

endmodule

// File: verif/gcv_checker.sv
// gcv_checker: watches the in, out and cfg channels of the gc victim selector,
// keeps its own block table and clean pool, and checks every out beat in order
// depends on gcv_pkg
`timescale 1ns / 1ps

module gcv_checker #(
  parameter int NUM_BLOCKS          = 1024,
  parameter int POOL_DEPTH          = 16,
  parameter int MAX_PAGES_PER_BLOCK = 256,
  parameter int BW                  = 10,
  parameter int CW                  = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [gcv_pkg::MODE_W-1:0]    mode_i,
  input  logic [BW-1:0]                 block_index_i,
  input  logic [CW-1:0]                 valid_pages_i,
  input  logic                          holds_data_i,
  input  logic                          region_one_i,
  input  logic [gcv_pkg::RND_W-1:0]     random_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [BW-1:0]                 chosen_block_i,
  input  logic [gcv_pkg::STATUS_W-1:0]  status_i,
  input  logic                          cfg_we_i,
  input  logic [gcv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CW-1:0]                 cfg_data_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            victims_o
);

  typedef struct packed {
    logic [BW-1:0]    block;
    gcv_pkg::status_e status;
  } pick_t;

  logic [CW-1:0] page_cnt [NUM_BLOCKS];
  bit            in_use [NUM_BLOCKS];
  bit            region_tbl [NUM_BLOCKS];
  logic [BW-1:0] clean_q [$];
  int            ppb;
  bit            excl;

  pick_t expected_picks_q [$];
  int    fails   = 0;
  int    checked = 0;
  int    victims = 0;

  task automatic reset_gc_state();
    int i;
    int b;
    for (i = 0; i < NUM_BLOCKS; i++) begin
      page_cnt[i]   = '0;
      in_use[i]     = 1'b1;
      region_tbl[i] = 1'b0;
    end
    clean_q.delete();
    // pool starts with the top blocks, highest at the head
    for (i = 0; i < POOL_DEPTH; i++) begin
      b = NUM_BLOCKS - 1 - (i % NUM_BLOCKS);
      clean_q.push_back(BW'(b));
      in_use[b] = 1'b0;
    end
    ppb  = (MAX_PAGES_PER_BLOCK < 64) ? MAX_PAGES_PER_BLOCK : 64;
    excl = 1'b0;
  endtask

  function automatic bit is_victim_candidate(int b);
    return in_use[b] && !(excl && region_tbl[b] && page_cnt[b] != 0);
  endfunction

  function automatic pick_t predict_pick(gcv_pkg::mode_e m, logic [BW-1:0] b,
                                         logic [CW-1:0] v, logic h, logic r,
                                         logic [gcv_pkg::RND_W-1:0] rnd);
    pick_t res;
    int    i;
    int    minv;
    int    ties;
    int    sel;
    int    seen;
    res.block  = '0;
    res.status = gcv_pkg::ST_OK;
    case (m)
      gcv_pkg::MODE_WRITE: begin
        page_cnt[b]   = v;
        in_use[b]     = h;
        region_tbl[b] = r;
      end
      gcv_pkg::MODE_RECLAIM: begin
        if (clean_q.size() >= POOL_DEPTH) begin
          res.status = gcv_pkg::ST_POOL_FULL;
        end else begin
          minv = ppb;
          ties = 0;
          for (i = 0; i < NUM_BLOCKS; i++) begin
            if (is_victim_candidate(i)) begin
              if (int'(page_cnt[i]) < minv) begin
                minv = int'(page_cnt[i]);
                ties = 1;
              end else if (int'(page_cnt[i]) == minv) begin
                ties++;
              end
            end
          end
          if (ties == 0 || minv >= ppb) begin
            res.status = gcv_pkg::ST_NO_SPACE;
          end else begin
            // tie pick counts up from the lowest block number
            sel  = int'(rnd) % ties;
            seen = 0;
            for (i = 0; i < NUM_BLOCKS; i++) begin
              if (is_victim_candidate(i) && int'(page_cnt[i]) == minv) begin
                if (seen == sel) begin
                  res.block = BW'(i);
                  break;
                end
                seen++;
              end
            end
            page_cnt[res.block] = '0;
            in_use[res.block]   = 1'b0;
            clean_q.push_back(res.block);
            victims++;
          end
        end
      end
      gcv_pkg::MODE_TAKE: begin
        if (clean_q.size() == 0) res.status = gcv_pkg::ST_POOL_EMPTY;
        else res.block = clean_q.pop_front();
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t got;
    pick_t want;
    if (!rst_ni) begin
      reset_gc_state();
      expected_picks_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == gcv_pkg::CFG_PAGES_PER_BLOCK) ppb = int'(cfg_data_i);
        else if (cfg_idx_i == gcv_pkg::CFG_REGION_EXCLUDE) excl = cfg_data_i[0];
      end
      if (out_valid_i && !out_stall_i) begin
        got.block  = chosen_block_i;
        got.status = gcv_pkg::status_e'(status_i);
        checked++;
        if (expected_picks_q.size() == 0) begin
          fails++;
          $error("out beat with nothing expected: chosen_block %0d status %0d",
                 got.block, got.status);
        end else begin
          want = expected_picks_q.pop_front();
          if (got.block !== want.block) begin
            fails++;
            $error("chosen_block: expected %0d, got %0d", want.block, got.block);
          end
          if (got.status !== want.status) begin
            fails++;
            $error("status: expected %0d, got %0d", want.status, got.status);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_picks_q.push_back(predict_pick(gcv_pkg::mode_e'(mode_i), block_index_i,
                                                valid_pages_i, holds_data_i,
                                                region_one_i, random_value_i));
      end
    end
    pending_o  <= expected_picks_q.size();
    fail_cnt_o <= fails;
    checked_o  <= checked;
    victims_o  <= victims;
  end

endmodule

// File: verif/tb.sv
// tb: stimulus and verdict for flash_gc_victim_and_free_pool_top
// drives the in, out-stall and cfg ports; checking is done by gcv_checker
// depends on gcv_pkg, gcv_checker and the rtl
`timescale 1ns / 1ps

module tb;

  localparam int NUM_BLOCKS  = 1024;
  localparam int POOL_DEPTH  = 16;
  localparam int MAX_PAGES   = 256;
  localparam int BW          = $clog2(NUM_BLOCKS);
  localparam int CW          = $clog2(MAX_PAGES + 1);
  localparam int HOLD_LEN    = 400;
  localparam int END_WAIT    = 2200;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [gcv_pkg::MODE_W-1:0]    mode_i;
  logic [BW-1:0]                 block_index_i;
  logic [CW-1:0]                 valid_pages_i;
  logic                          holds_data_i;
  logic                          region_one_i;
  logic [gcv_pkg::RND_W-1:0]     random_value_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [BW-1:0]                 chosen_block_o;
  logic [gcv_pkg::STATUS_W-1:0]  status_o;
  logic                          cfg_we_i;
  logic [gcv_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CW-1:0]                 cfg_data_i;

  int fail_cnt;
  int pending;
  int checked;
  int victims;

  int tx_pct     = 0;
  int rx_pct     = 0;
  int hold_reqs  = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int cycle_cnt  = 0;
  int n_sent     = 0;
  int n_settings = 0;

  flash_gc_victim_and_free_pool_top #(
    .NUM_BLOCKS          (NUM_BLOCKS),
    .POOL_DEPTH          (POOL_DEPTH),
    .MAX_PAGES_PER_BLOCK (MAX_PAGES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .block_index_i  (block_index_i),
    .valid_pages_i  (valid_pages_i),
    .holds_data_i   (holds_data_i),
    .region_one_i   (region_one_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chosen_block_o (chosen_block_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  gcv_checker #(
    .NUM_BLOCKS          (NUM_BLOCKS),
    .POOL_DEPTH          (POOL_DEPTH),
    .MAX_PAGES_PER_BLOCK (MAX_PAGES),
    .BW                  (BW),
    .CW                  (CW)
  ) i_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .mode_i         (mode_i),
    .block_index_i  (block_index_i),
    .valid_pages_i  (valid_pages_i),
    .holds_data_i   (holds_data_i),
    .region_one_i   (region_one_i),
    .random_value_i (random_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chosen_block_i (chosen_block_o),
    .status_i       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .checked_o      (checked),
    .victims_o      (victims)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: a requested long hold first, otherwise random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
    end
  end

  task automatic send_beat(input gcv_pkg::mode_e m, input logic [BW-1:0] b,
                           input logic [CW-1:0] v, input logic h, input logic r,
                           input logic [gcv_pkg::RND_W-1:0] rnd);
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    block_index_i  <= b;
    valid_pages_i  <= v;
    holds_data_i   <= h;
    region_one_i   <= r;
    random_value_i <= rnd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // mostly well-formed beats, writes with small counts so ties and thresholds matter
  task automatic send_random_beat();
    int            sel;
    logic [CW-1:0] v;
    sel = $urandom_range(99);
    v   = ($urandom_range(7) == 0) ? CW'($urandom_range(MAX_PAGES)) : CW'($urandom_range(12));
    if (sel < 45)
      send_beat(gcv_pkg::MODE_WRITE, BW'($urandom_range(NUM_BLOCKS - 1)), v,
                $urandom_range(9) != 0, $urandom_range(2) == 0,
                gcv_pkg::RND_W'($urandom));
    else if (sel < 72)
      send_beat(gcv_pkg::MODE_RECLAIM, BW'($urandom), CW'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)), gcv_pkg::RND_W'($urandom));
    else if (sel < 95)
      send_beat(gcv_pkg::MODE_TAKE, BW'($urandom), CW'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)), gcv_pkg::RND_W'($urandom));
    else
      send_beat(gcv_pkg::MODE_RSVD, BW'($urandom), CW'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)), gcv_pkg::RND_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // both registers back to back; only while the block is idle, left to the caller
  task automatic load_gc_settings(input int ppb, input bit excl);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= gcv_pkg::CFG_PAGES_PER_BLOCK;
    cfg_data_i <= CW'(ppb);
    @(posedge clk_i);
    cfg_idx_i  <= gcv_pkg::CFG_REGION_EXCLUDE;
    cfg_data_i <= CW'(excl);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input int ppb, input bit excl, input int tx, input int rx,
                           input int n);
    wait_drained();
    load_gc_settings(ppb, excl);
    tx_pct = tx;
    rx_pct = rx;
    repeat (n) send_random_beat();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = gcv_pkg::MODE_WRITE;
    block_index_i  = '0;
    valid_pages_i  = '0;
    holds_data_i   = 1'b0;
    region_one_i   = 1'b0;
    random_value_i = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = gcv_pkg::CFG_PAGES_PER_BLOCK;
    cfg_data_i     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_gc_settings(64, 1'b0);

    // directed: full pool, record extremes, reserved mode, empty the pool
    send_beat(gcv_pkg::MODE_RECLAIM, '0, '0, 1'b0, 1'b0, '1);
    send_beat(gcv_pkg::MODE_WRITE, BW'(NUM_BLOCKS - 1), CW'(MAX_PAGES), 1'b1, 1'b1, '0);
    send_beat(gcv_pkg::MODE_WRITE, '0, '0, 1'b0, 1'b0, '1);
    send_beat(gcv_pkg::MODE_RSVD, '1, '1, 1'b1, 1'b1, '1);
    repeat (POOL_DEPTH + 1) send_beat(gcv_pkg::MODE_TAKE, '0, '0, 1'b0, 1'b0, '0);
    send_beat(gcv_pkg::MODE_RECLAIM, '1, '1, 1'b1, 1'b1, '1);
    send_beat(gcv_pkg::MODE_RECLAIM, '0, '0, 1'b0, 1'b0, '0);
    send_beat(gcv_pkg::MODE_TAKE, '1, '1, 1'b1, 1'b1, '1);

    run_phase(64, 1'b0, 0, 0, 50);
    run_phase(0, 1'b1, 50, 0, 25);
    run_phase(256, 1'b0, 0, 50, 35);
    run_phase(256, 1'b1, 20, 20, 30);

    // long output hold while writes keep coming so the input backs up
    wait_drained();
    load_gc_settings(5, 1'b0);
    tx_pct = 0;
    rx_pct = 0;
    hold_reqs++;
    repeat (12) send_beat(gcv_pkg::MODE_WRITE, BW'($urandom), CW'($urandom_range(1, 12)),
                          1'b1, 1'($urandom_range(1)), gcv_pkg::RND_W'($urandom));
    rx_pct = 50;
    repeat (50) send_random_beat();

    run_phase(255, 1'b1, 0, 0, 40);
    run_phase(1, 1'b0, 50, 0, 30);

    wait_drained();
    repeat (END_WAIT) @(posedge clk_i);
    $display("summary: %0d in beats over %0d register settings, %0d out beats checked,",
             n_sent, n_settings, checked);
    $display("summary: %0d victims reclaimed, one long output hold with the input backed up",
             victims);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/gcv_pkg.sv
rtl/gcv_ram.sv
rtl/gcv_rem.sv
rtl/flash_gc_victim_and_free_pool_top.sv
verif/gcv_checker.sv
verif/tb.sv
